// ===== rtl/atrlc_pkg.sv =====
// Shared types, pattern text and per-byte line update for the modem response classifier.
// Depends on nothing; used by atrlc_classify and at_response_line_classifier_core.
`timescale 1ns / 1ps

package atrlc_pkg;

  // pattern_alive bit positions
  localparam int unsigned PAT_OK    = 0;
  localparam int unsigned PAT_ERR   = 1;
  localparam int unsigned PAT_NOC   = 2;
  localparam int unsigned PAT_CME   = 3;
  localparam int unsigned PAT_CPIN  = 4;
  localparam int unsigned PAT_CSQ   = 5;
  localparam int unsigned PAT_AT    = 6;
  localparam int unsigned PAT_READY = 7;

  // number_flags bit positions
  localparam int unsigned NF_DIGIT  = 0;
  localparam int unsigned NF_COMMA  = 1;
  localparam int unsigned NF_SECOND = 2;
  localparam int unsigned NF_FAIL   = 3;

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  localparam logic CMD_BYTE  = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  // Pattern text, right aligned: first character sits in the highest used byte
  localparam logic [95:0] TXT_OK    = 96'("OK");
  localparam logic [95:0] TXT_ERR   = 96'("ERROR");
  localparam logic [95:0] TXT_NOC   = 96'("NO CARRIER");
  localparam logic [95:0] TXT_CME   = 96'("+CME ERROR: ");
  localparam logic [95:0] TXT_CPIN  = 96'("+CPIN: ");
  localparam logic [95:0] TXT_CSQ   = 96'("+CSQ: ");
  localparam logic [95:0] TXT_AT    = 96'("AT");
  localparam logic [95:0] TXT_READY = 96'("READY");

  localparam logic [4:0] LEN_OK    = 5'd2;
  localparam logic [4:0] LEN_ERR   = 5'd5;
  localparam logic [4:0] LEN_NOC   = 5'd10;
  localparam logic [4:0] LEN_CME   = 5'd12;
  localparam logic [4:0] LEN_CPIN  = 5'd7;
  localparam logic [4:0] LEN_CSQ   = 5'd6;
  localparam logic [4:0] LEN_AT    = 5'd2;
  localparam logic [4:0] LEN_READY = 5'd5;

  localparam logic [4:0] POS_MAX    = 5'd31;
  localparam logic [7:0] RSSI_LIMIT = 8'd31;
  localparam logic [5:0] LEVEL_FULL = 6'd32;

  localparam int unsigned CME_COUNT = 15;
  localparam logic [7:0] CME_CODES [CME_COUNT] = '{
    8'd0, 8'd1, 8'd3, 8'd4, 8'd10, 8'd11, 8'd12, 8'd13, 8'd14, 8'd15,
    8'd20, 8'd21, 8'd30, 8'd31, 8'd32
  };

  typedef enum logic [3:0] {
    CLS_INIT_IGNORED,
    CLS_INITIALIZED,
    CLS_ECHO,
    CLS_OK,
    CLS_FINAL_ERROR,
    CLS_CME,
    CLS_PIN_READY,
    CLS_PIN_NOT_READY,
    CLS_SIGNAL,
    CLS_UNRECOGNIZED
  } line_class_t;

  typedef struct packed {
    logic       content_ended;
    logic [4:0] char_position;
    logic [7:0] pattern_alive;
    logic [7:0] number_accum;
    logic [3:0] number_flags;
  } line_state_t;

  localparam line_state_t LINE_CLEAR = '{
    content_ended: 1'b0,
    char_position: 5'd0,
    pattern_alive: 8'hFF,
    number_accum:  8'd0,
    number_flags:  4'd0
  };

  typedef struct packed {
    line_class_t line_class;
    logic        answered;
    logic        final_error_kind;
    logic [3:0]  cme_message;
    logic [5:0]  strength_level;
    logic [7:0]  rssi_value;
  } result_t;

  // Character p of a right-aligned text of length len; zero past the end
  function automatic logic [7:0] char_at(input logic [95:0] txt, input logic [4:0] len,
                                         input logic [4:0] p);
    logic [4:0] idx;
    idx = len - 5'd1 - p;
    if (p < len) begin
      return txt[{idx[3:0], 3'b000} +: 8];
    end
    return CHAR_NUL;
  endfunction

  // acc * 10 + digit, saturated at 255
  function automatic logic [7:0] accum_digit(input logic [7:0] acc, input logic [7:0] b);
    logic [11:0] v;
    v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {4'd0, b - CHAR_ZERO};
    return (v > 12'd255) ? 8'hFF : v[7:0];
  endfunction

  // Advance the line state by one content byte
  function automatic line_state_t feed_byte(input line_state_t s, input logic [7:0] b);
    line_state_t n;
    logic [4:0]  p;
    logic        digit;
    n = s;
    p = s.char_position;
    digit = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
    if (s.content_ended) begin
      return n;
    end
    if (b == CHAR_NUL) begin
      n.content_ended = 1'b1;
      return n;
    end
    // exact patterns
    if (p >= LEN_OK || char_at(TXT_OK, LEN_OK, p) != b) n.pattern_alive[PAT_OK] = 1'b0;
    if (p >= LEN_ERR || char_at(TXT_ERR, LEN_ERR, p) != b) n.pattern_alive[PAT_ERR] = 1'b0;
    if (p >= LEN_NOC || char_at(TXT_NOC, LEN_NOC, p) != b) n.pattern_alive[PAT_NOC] = 1'b0;
    // prefix patterns
    if (p < LEN_CME && char_at(TXT_CME, LEN_CME, p) != b) n.pattern_alive[PAT_CME] = 1'b0;
    if (p < LEN_CPIN && char_at(TXT_CPIN, LEN_CPIN, p) != b) n.pattern_alive[PAT_CPIN] = 1'b0;
    if (p < LEN_CSQ && char_at(TXT_CSQ, LEN_CSQ, p) != b) n.pattern_alive[PAT_CSQ] = 1'b0;
    if (p < LEN_AT && char_at(TXT_AT, LEN_AT, p) != b) n.pattern_alive[PAT_AT] = 1'b0;
    // READY follows the CPIN prefix
    if (p >= LEN_CPIN) begin
      if (p >= LEN_CPIN + LEN_READY ||
          char_at(TXT_READY, LEN_READY, p - LEN_CPIN) != b) begin
        n.pattern_alive[PAT_READY] = 1'b0;
      end
    end
    if (n.pattern_alive[PAT_CME] && p >= LEN_CME && !n.number_flags[NF_FAIL]) begin
      if (digit) begin
        n.number_accum = accum_digit(n.number_accum, b);
        n.number_flags[NF_DIGIT] = 1'b1;
      end else begin
        n.number_flags[NF_FAIL] = 1'b1;
      end
    end
    if (n.pattern_alive[PAT_CSQ] && p >= LEN_CSQ &&
        !n.number_flags[NF_FAIL] && !n.number_flags[NF_SECOND]) begin
      if (!n.number_flags[NF_COMMA]) begin
        if (digit) begin
          n.number_accum = accum_digit(n.number_accum, b);
          n.number_flags[NF_DIGIT] = 1'b1;
        end else if (b == CHAR_COMMA && n.number_flags[NF_DIGIT]) begin
          n.number_flags[NF_COMMA] = 1'b1;
        end else begin
          n.number_flags[NF_FAIL] = 1'b1;
        end
      end else if (digit) begin
        n.number_flags[NF_SECOND] = 1'b1;
      end else begin
        n.number_flags[NF_FAIL] = 1'b1;
      end
    end
    n.char_position = (p < POS_MAX) ? p + 5'd1 : POS_MAX;
    return n;
  endfunction

endpackage

// ===== rtl/atrlc_classify.sv =====
// Line-end classification: turns the matcher state of a finished line into one result.
// Depends on atrlc_pkg.
`timescale 1ns / 1ps

module atrlc_classify (
  input  logic                 modem_ready,
  input  atrlc_pkg::line_state_t line_state,
  output logic                 has_result,
  output logic                 set_ready,
  output atrlc_pkg::result_t   result
);
  import atrlc_pkg::*;

  logic [4:0] p;
  logic [7:0] a;
  logic [3:0] f;
  logic       is_ok;
  logic       cme_found;
  logic [3:0] cme_index;

  assign p = line_state.char_position;
  assign a = line_state.pattern_alive;
  assign f = line_state.number_flags;
  assign is_ok = a[PAT_OK] && p == LEN_OK;

  // Search the known code list; first hit wins
  always_comb begin
    cme_found = 1'b0;
    cme_index = 4'd0;
    for (int i = CME_COUNT - 1; i >= 0; i--) begin
      if (CME_CODES[i] == line_state.number_accum) begin
        cme_found = 1'b1;
        cme_index = 4'(i);
      end
    end
  end

  always_comb begin
    has_result = (p != 5'd0);
    set_ready  = 1'b0;
    result     = '{line_class: CLS_UNRECOGNIZED, answered: 1'b0, final_error_kind: 1'b0,
                   cme_message: 4'd0, strength_level: 6'd0, rssi_value: 8'd0};
    priority if (!modem_ready) begin
      if (is_ok) begin
        set_ready = 1'b1;
        result.line_class = CLS_INITIALIZED;
      end else begin
        result.line_class = CLS_INIT_IGNORED;
      end
    end else if (a[PAT_AT] && p >= LEN_AT) begin
      result.line_class = CLS_ECHO;
    end else if (is_ok) begin
      result.line_class = CLS_OK;
      result.answered   = 1'b1;
    end else if (a[PAT_ERR] && p == LEN_ERR) begin
      result.line_class = CLS_FINAL_ERROR;
      result.answered   = 1'b1;
    end else if (a[PAT_NOC] && p == LEN_NOC) begin
      result.line_class       = CLS_FINAL_ERROR;
      result.answered         = 1'b1;
      result.final_error_kind = 1'b1;
    end else if (a[PAT_CME] && p >= LEN_CME) begin
      if (f[NF_DIGIT] && !f[NF_FAIL] && cme_found) begin
        result.line_class  = CLS_CME;
        result.cme_message = cme_index;
      end
    end else if (a[PAT_CPIN] && p >= LEN_CPIN) begin
      result.line_class = (a[PAT_READY] && p == LEN_CPIN + LEN_READY) ?
                          CLS_PIN_READY : CLS_PIN_NOT_READY;
    end else if (a[PAT_CSQ] && p >= LEN_CSQ && f[NF_SECOND]) begin
      result.line_class     = CLS_SIGNAL;
      result.rssi_value     = line_state.number_accum;
      result.strength_level = (line_state.number_accum > RSSI_LIMIT) ?
                              LEVEL_FULL : line_state.number_accum[5:0];
    end else begin
      result.line_class = CLS_UNRECOGNIZED;
    end
  end

endmodule

// ===== rtl/at_response_line_classifier_core.sv =====
// Modem response line classifier, top level: input register, line matcher, result register.
// Depends on atrlc_pkg and atrlc_classify.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------------------------
//  in      | receive   | in_valid / in_stall  | command, rx_byte
//  out     | send      | out_valid / out_stall| line_class, answered, final_error_kind,
//          |           |                      | cme_message, strength_level, rssi_value
//
// One beat per cycle while no stalled result holds the flow; the LF beat that ends a line passes the
// input register, and its result is then registered in the result register. The matcher state updates
// from the input register, so bytes stream back to back. rst (synchronous) returns to init mode and
// clears the partial line. out_stall holds the result register; the input register then holds too, and in_stall rises.
`timescale 1ns / 1ps

module at_response_line_classifier_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       command,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [3:0] line_class,
  output logic       answered,
  output logic       final_error_kind,
  output logic [3:0] cme_message,
  output logic [5:0] strength_level,
  output logic [7:0] rssi_value
);
  import atrlc_pkg::*;

  logic        s1_valid;
  logic        s1_command;
  logic [7:0]  s1_byte;
  logic        fire;

  line_state_t line_state;
  line_state_t line_state_next;
  line_state_t after_cr;
  logic        pending_cr;
  logic        pending_cr_next;
  logic        modem_ready;

  logic        line_end;
  logic        has_result;
  logic        set_ready;
  result_t     result;
  result_t     out_result;
  logic        emit;

  assign fire     = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= (in_valid && !in_stall) || (s1_valid && !fire);
    end
    if (in_valid && !in_stall) begin
      s1_command <= command;
      s1_byte    <= rx_byte;
    end
  end

  atrlc_classify u_classify (
    .modem_ready (modem_ready),
    .line_state  (line_state),
    .has_result  (has_result),
    .set_ready   (set_ready),
    .result      (result)
  );

  assign line_end = (s1_command == CMD_BYTE) && pending_cr && (s1_byte == CHAR_LF);
  assign emit     = fire && line_end && has_result;

  always_comb begin
    after_cr        = pending_cr ? feed_byte(line_state, CHAR_CR) : line_state;
    line_state_next = line_state;
    pending_cr_next = pending_cr;
    if (s1_command == CMD_FLUSH || line_end) begin
      line_state_next = LINE_CLEAR;
      pending_cr_next = 1'b0;
    end else if (s1_byte == CHAR_CR) begin
      // a held CR that is not followed by LF is content
      line_state_next = after_cr;
      pending_cr_next = 1'b1;
    end else begin
      line_state_next = feed_byte(after_cr, s1_byte);
      pending_cr_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_state  <= LINE_CLEAR;
      pending_cr  <= 1'b0;
      modem_ready <= 1'b0;
    end else if (fire) begin
      line_state  <= line_state_next;
      pending_cr  <= pending_cr_next;
      if (emit && set_ready) begin
        modem_ready <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= emit || (out_valid && out_stall);
    end
    if (emit) begin
      out_result <= result;
    end
  end

  assign line_class       = out_result.line_class;
  assign answered         = out_result.answered;
  assign final_error_kind = out_result.final_error_kind;
  assign cme_message      = out_result.cme_message;
  assign strength_level   = out_result.strength_level;
  assign rssi_value       = out_result.rssi_value;

endmodule
